/* rtl/one_pole_bandpass_filter_macros.svh */
// ----------------------------------------------------------------------------
// One-pole bandpass filter: assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ONE_POLE_BANDPASS_FILTER_MACROS_SVH
`define ONE_POLE_BANDPASS_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// condition a must see b in the same cycle
`define OPBF_ASSERT_NOW(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("assertion failed: same-cycle implication");

// condition a must see b in the following cycle
`define OPBF_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("assertion failed: next-cycle implication");

`else

`define OPBF_ASSERT_NOW(lbl, a, b)
`define OPBF_ASSERT_NEXT(lbl, a, b)

`endif

`endif

/* rtl/opbf_pkg.sv */
// ----------------------------------------------------------------------------
// One-pole bandpass filter package
// Field types, register indexes and fixed constants shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package opbf_pkg;

	localparam int SAMPLE_W = 24;
	localparam int CHAN_W   = 3;
	localparam int ALPHA_W  = 16;
	localparam int DIGIT_W  = 4;
	localparam int DIGITS   = ALPHA_W / DIGIT_W;
	localparam int DCNT_W   = $clog2(DIGITS);
	localparam int CFG_IDX_W = 1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [CHAN_W-1:0]          chan_t;
	typedef logic [ALPHA_W-1:0]         alpha_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

	// register indexes
	localparam cfg_idx_t REG_LP_ALPHA = 1'd0;
	localparam cfg_idx_t REG_HP_ALPHA = 1'd1;

	localparam alpha_t LP_ALPHA_RST = 16'hFFFF;
	localparam alpha_t HP_ALPHA_RST = 16'h0000;

	// output saturation limits
	localparam sample_t OUT_MAX = 24'sh7FFFFF;
	localparam sample_t OUT_MIN = -24'sh800000;

endpackage

`default_nettype wire

/* rtl/opbf_in_if.sv */
// ----------------------------------------------------------------------------
// Sample input channel
// Valid/ready channel carrying one audio sample and its channel number.
// ----------------------------------------------------------------------------
`default_nettype none

interface opbf_in_if;
	logic              valid;
	logic              ready;
	opbf_pkg::sample_t sample_in;
	opbf_pkg::chan_t   channel;

	modport source (output valid, output sample_in, output channel, input ready);
	modport sink   (input valid, input sample_in, input channel, output ready);
endinterface

`default_nettype wire

/* rtl/opbf_out_if.sv */
// ----------------------------------------------------------------------------
// Sample output channel
// Valid/ready channel carrying one filtered sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface opbf_out_if;
	logic              valid;
	logic              ready;
	opbf_pkg::sample_t sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

/* rtl/opbf_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module opbf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  wire                                   clk,
	input  wire                                   we,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                      wdata,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/one_pole_bandpass_filter.sv */
// ----------------------------------------------------------------------------
// One-pole bandpass filter
// Per-channel lowpass then highpass, output is lowpass minus highpass.
// ----------------------------------------------------------------------------
// Usage:
//   sample_ch takes one transaction per sample: a signed 24-bit sample and a
//   channel number. result_ch returns exactly one filtered sample per input
//   transaction, in order. Channel numbers at or above CHANNELS leave the
//   state alone and return zero.
//   cfg_we/cfg_index/cfg_data write lp_alpha (index 0) and hp_alpha (index 1).
//   The user must do so only while the block is idle; the block does not enforce it.
// Timing:
//   An in-range sample goes from acceptance through a RAM read state, two
//   passes through the 4-bit digit multiplier (one per coefficient) with
//   set-up and update states around them, and a done state. Out-of-range
//   channels go from the read state straight to the done state. The next
//   sample is taken the cycle after the result enters the output register,
//   so the block takes no new sample while one is being computed.
// Reset:
//   arst_n clears all filter levels (through per-channel valid bits, no
//   clearing pass), sets lp_alpha to 65535 and hp_alpha to 0.
// Stall: a result waiting in the output register does not block the next
//   input transaction; computation holds in its final state until the
//   register is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "one_pole_bandpass_filter_macros.svh"

module one_pole_bandpass_filter #(
	parameter int CHANNELS        = 8,
	parameter int STATE_FRAC_BITS = 8
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire opbf_pkg::cfg_idx_t     cfg_index,
	input  wire opbf_pkg::alpha_t       cfg_data,
	opbf_in_if.sink                     sample_ch,
	opbf_out_if.source                  result_ch
);

	localparam int LW  = opbf_pkg::SAMPLE_W + STATE_FRAC_BITS;   // level width
	localparam int DW  = LW + 1;                                 // difference width
	localparam int PW  = DW + opbf_pkg::ALPHA_W;                 // product width
	localparam int CW  = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
	localparam logic [DW-1:0] FRAC_MASK = DW'((64'd1 << STATE_FRAC_BITS) - 64'd1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_LPM  = 3'd2;
	localparam logic [2:0] S_LPU  = 3'd3;
	localparam logic [2:0] S_HPD  = 3'd4;
	localparam logic [2:0] S_HPM  = 3'd5;
	localparam logic [2:0] S_HPU  = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0]                    state_q;
	opbf_pkg::alpha_t              lp_alpha_q, hp_alpha_q;
	opbf_pkg::sample_t             x_q;
	logic [CW-1:0]                 addr_q;
	logic                          ok_q;
	logic                          vld_s1;
	logic [CHANNELS-1:0]           vld_q;
	logic signed [LW-1:0]          lp_q, hp_q;
	logic signed [DW-1:0]          d_q;
	opbf_pkg::alpha_t              dig_q;
	logic signed [PW-1:0]          acc_q;
	logic [opbf_pkg::DCNT_W-1:0]   dcnt_q;
	logic                          out_valid_q;
	opbf_pkg::sample_t             out_data_q;

	logic                          accept;
	logic                          in_ok;
	logic [CW-1:0]                 in_addr;
	logic [2*LW-1:0]               ram_rdata;
	logic                          ram_we;
	logic signed [LW-1:0]          rd_lp, rd_hp, x_ext;
	logic signed [DW+opbf_pkg::DIGIT_W:0] dig_prod;
	logic signed [PW-1:0]          acc_next;
	logic signed [LW-1:0]          step;
	logic                          out_free;
	logic signed [DW-1:0]          diff, quo, quo_t;
	opbf_pkg::sample_t             y;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_alpha_q <= opbf_pkg::LP_ALPHA_RST;
			hp_alpha_q <= opbf_pkg::HP_ALPHA_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				opbf_pkg::REG_LP_ALPHA: lp_alpha_q <= cfg_data;
				opbf_pkg::REG_HP_ALPHA: hp_alpha_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input handshake and channel decode
	assign sample_ch.ready = (state_q == S_IDLE);
	assign accept   = sample_ch.valid && sample_ch.ready;
	assign in_ok    = (32'(sample_ch.channel) < CHANNELS);
	assign in_addr  = CW'(sample_ch.channel);
	assign out_free = !out_valid_q || result_ch.ready;
	assign ram_we   = (state_q == S_DONE) && ok_q && out_free;

	// state storage: {hp, lp} per channel
	opbf_ram #(
		.WIDTH (2 * LW),
		.DEPTH (CHANNELS)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata ({hp_q, lp_q}),
		.raddr (in_addr),
		.rdata (ram_rdata)
	);

	// never-written channels read as zero
	assign rd_lp = vld_s1 ? $signed(ram_rdata[LW-1:0])    : '0;
	assign rd_hp = vld_s1 ? $signed(ram_rdata[2*LW-1:LW]) : '0;
	assign x_ext = LW'(x_q) <<< STATE_FRAC_BITS;

	// digit-serial multiply, most significant coefficient digit first
	assign dig_prod = d_q * $signed({1'b0, dig_q[opbf_pkg::ALPHA_W-1 -: opbf_pkg::DIGIT_W]});
	assign acc_next = (acc_q <<< opbf_pkg::DIGIT_W) + PW'(dig_prod);
	assign step     = LW'(acc_q >>> opbf_pkg::ALPHA_W);

	// output: truncate toward zero, then saturate
	assign diff  = DW'(lp_q) - DW'(hp_q);
	assign quo   = diff >>> STATE_FRAC_BITS;
	assign quo_t = quo + DW'(diff[DW-1] && ((diff & FRAC_MASK) != '0));
	always_comb begin
		if (!ok_q) begin
			y = '0;
		end else if (quo_t > DW'(opbf_pkg::OUT_MAX)) begin
			y = opbf_pkg::OUT_MAX;
		end else if (quo_t < DW'(opbf_pkg::OUT_MIN)) begin
			y = opbf_pkg::OUT_MIN;
		end else begin
			y = opbf_pkg::SAMPLE_W'(quo_t);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dcnt_q  <= '0;
			vld_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					dcnt_q  <= '0;
					state_q <= ok_q ? S_LPM : S_DONE;
				end
				S_LPM: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == opbf_pkg::DCNT_W'(opbf_pkg::DIGITS - 1)) begin
						state_q <= S_LPU;
					end
				end
				S_LPU: state_q <= S_HPD;
				S_HPD: begin
					dcnt_q  <= '0;
					state_q <= S_HPM;
				end
				S_HPM: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == opbf_pkg::DCNT_W'(opbf_pkg::DIGITS - 1)) begin
						state_q <= S_HPU;
					end
				end
				S_HPU: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (ok_q) begin
							vld_q[addr_q] <= 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= sample_ch.sample_in;
			addr_q <= in_addr;
			ok_q   <= in_ok;
			vld_s1 <= in_ok ? vld_q[in_addr] : 1'b0;
		end
		case (state_q)
			S_READ: begin
				lp_q  <= rd_lp;
				hp_q  <= rd_hp;
				d_q   <= DW'(x_ext) - DW'(rd_lp);
				dig_q <= lp_alpha_q;
				acc_q <= '0;
			end
			S_LPM, S_HPM: begin
				acc_q <= acc_next;
				dig_q <= dig_q << opbf_pkg::DIGIT_W;
			end
			S_LPU: lp_q <= lp_q + step;
			S_HPD: begin
				d_q   <= DW'(lp_q) - DW'(hp_q);
				dig_q <= hp_alpha_q;
				acc_q <= '0;
			end
			S_HPU: hp_q <= hp_q + step;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_data_q <= y;
		end
	end

	assign result_ch.valid      = out_valid_q;
	assign result_ch.sample_out = out_data_q;

	// checks
	`OPBF_ASSERT_NEXT(a_accept_reads, accept, state_q == S_READ)
	`OPBF_ASSERT_NOW(a_wr_in_range, ram_we, ok_q && state_q == S_DONE)
	`OPBF_ASSERT_NOW(a_no_accept_busy, state_q != S_IDLE, !accept)
	`OPBF_ASSERT_NEXT(a_wr_sets_valid, ram_we, vld_q[$past(addr_q)])

endmodule

`default_nettype wire

/* tb/tb_one_pole_bandpass_filter.sv */
// ----------------------------------------------------------------------------
// One-pole bandpass filter testbench
// Drives audio samples on all channels through a range of lowpass/highpass
// coefficient settings. Each result is checked against a per-channel Q24.8
// model of the two filter levels held in the testbench. Both sides of the
// block idle at random, apart from one stretch with no idling at all.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_one_pole_bandpass_filter;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_CHANNELS  = 8;
	localparam int FRAC_BITS     = 8;
	localparam int IDLE_PERCENT  = 20;
	localparam int QUIET_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_REPORTS   = 40;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	opbf_pkg::cfg_idx_t cfg_index;
	opbf_pkg::alpha_t   cfg_data;

	opbf_in_if  sample_if ();
	opbf_out_if result_if ();

	one_pole_bandpass_filter #(
		.CHANNELS        (NUM_CHANNELS),
		.STATE_FRAC_BITS (FRAC_BITS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample_ch (sample_if),
		.result_ch (result_if)
	);

	// model state: coefficients and the two levels per channel
	opbf_pkg::alpha_t  lp_coef = opbf_pkg::LP_ALPHA_RST;
	opbf_pkg::alpha_t  hp_coef = opbf_pkg::HP_ALPHA_RST;
	longint            lowpass_level [NUM_CHANNELS];
	longint            highpass_level[NUM_CHANNELS];
	opbf_pkg::sample_t expected_samples[$];

	opbf_pkg::sample_t tone_base[NUM_CHANNELS];
	bit                no_gaps;
	int                errors;
	int                quiet_cycles;
	opbf_pkg::sample_t want;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// lowpass then highpass on one channel, returns lowpass minus highpass
	function automatic opbf_pkg::sample_t predict_bandpass(opbf_pkg::sample_t s,
			opbf_pkg::chan_t c);
		longint x;
		longint lp;
		longint hp;
		longint q;
		if (c >= NUM_CHANNELS) begin
			return '0;
		end
		x  = longint'(s) * (longint'(1) << FRAC_BITS);
		lp = lowpass_level[c];
		hp = highpass_level[c];
		// products are exact; >>> on a signed value rounds toward minus infinity
		lp = lp + (((x - lp) * longint'(lp_coef)) >>> opbf_pkg::ALPHA_W);
		hp = hp + (((lp - hp) * longint'(hp_coef)) >>> opbf_pkg::ALPHA_W);
		lowpass_level[c]  = lp;
		highpass_level[c] = hp;
		// signed division truncates toward zero
		q = (lp - hp) / (longint'(1) << FRAC_BITS);
		if (q > longint'(opbf_pkg::OUT_MAX)) begin
			q = longint'(opbf_pkg::OUT_MAX);
		end
		if (q < longint'(opbf_pkg::OUT_MIN)) begin
			q = longint'(opbf_pkg::OUT_MIN);
		end
		return opbf_pkg::sample_t'(q);
	endfunction

	// one input transaction, with a random hold-off in front of it
	task automatic send_sample(input opbf_pkg::sample_t s, input opbf_pkg::chan_t c);
		while (!no_gaps && $urandom_range(99) < IDLE_PERCENT) begin
			sample_if.valid <= 1'b0;
			@(posedge clk);
		end
		sample_if.valid     <= 1'b1;
		sample_if.sample_in <= s;
		sample_if.channel   <= c;
		do begin
			@(posedge clk);
		end while (!sample_if.ready);
		expected_samples.push_back(predict_bandpass(s, c));
	endtask

	// stop sending and wait until every result is back
	task automatic wait_for_results();
		sample_if.valid <= 1'b0;
		while (expected_samples.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// write both coefficients; only called with nothing in flight
	task automatic set_coefficients(input opbf_pkg::alpha_t lp, input opbf_pkg::alpha_t hp);
		cfg_we    <= 1'b1;
		cfg_index <= opbf_pkg::REG_LP_ALPHA;
		cfg_data  <= lp;
		@(posedge clk);
		cfg_index <= opbf_pkg::REG_HP_ALPHA;
		cfg_data  <= hp;
		@(posedge clk);
		cfg_we <= 1'b0;
		lp_coef = lp;
		hp_coef = hp;
		@(posedge clk);
	endtask

	function automatic opbf_pkg::alpha_t pick_alpha();
		case ($urandom_range(6))
			0: return '0;
			1: return '1;
			2: return opbf_pkg::alpha_t'(1);
			3: return opbf_pkg::alpha_t'(16'h8000);
			4: return opbf_pkg::alpha_t'($urandom_range(2047));
			default: return opbf_pkg::alpha_t'($urandom);
		endcase
	endfunction

	// full-range noise, extremes, small values near zero and values near a per-channel level
	function automatic opbf_pkg::sample_t pick_sample(opbf_pkg::chan_t c);
		int v;
		case ($urandom_range(9))
			0: return opbf_pkg::OUT_MAX;
			1: return opbf_pkg::OUT_MIN;
			2: begin
				v = int'($urandom_range(511)) - 256;
				return opbf_pkg::sample_t'(v);
			end
			3, 4, 5: begin
				v = int'($urandom_range(4095)) - 2048;
				return tone_base[c] + opbf_pkg::sample_t'(v);
			end
			default: return opbf_pkg::sample_t'($urandom);
		endcase
	endfunction

	// --- tests ---

	// reset coefficients: lowpass moves 65535/65536 of the way to the sample, highpass frozen at zero
	task automatic test_reset_state();
		send_sample(opbf_pkg::OUT_MAX, opbf_pkg::chan_t'(0));
		send_sample(opbf_pkg::OUT_MIN, opbf_pkg::chan_t'(7));
		send_sample(opbf_pkg::sample_t'(0), opbf_pkg::chan_t'(3));
		send_sample(opbf_pkg::sample_t'(-1), opbf_pkg::chan_t'(1));
		send_sample(opbf_pkg::sample_t'(1), opbf_pkg::chan_t'(2));
		wait_for_results();
	endtask

	// both coefficients at zero, full scale and smallest non-zero step
	task automatic test_coefficient_extremes();
		set_coefficients('0, '0);
		send_sample(opbf_pkg::OUT_MAX, opbf_pkg::chan_t'(4));
		send_sample(opbf_pkg::OUT_MIN, opbf_pkg::chan_t'(0));
		wait_for_results();
		set_coefficients('1, '1);
		send_sample(opbf_pkg::OUT_MIN, opbf_pkg::chan_t'(4));
		send_sample(opbf_pkg::sample_t'(24'h555555), opbf_pkg::chan_t'(2));
		wait_for_results();
		set_coefficients(opbf_pkg::alpha_t'(1), opbf_pkg::alpha_t'(1));
		send_sample(opbf_pkg::OUT_MAX, opbf_pkg::chan_t'(3));
		send_sample(opbf_pkg::sample_t'(24'hAAAAAA), opbf_pkg::chan_t'(1));
		wait_for_results();
	endtask

	// highpass parked at one rail, lowpass driven to the other: output saturates
	task automatic test_saturation();
		set_coefficients('1, '1);
		repeat (3) send_sample(opbf_pkg::OUT_MAX, opbf_pkg::chan_t'(5));
		repeat (3) send_sample(opbf_pkg::OUT_MIN, opbf_pkg::chan_t'(6));
		wait_for_results();
		set_coefficients('1, '0);
		send_sample(opbf_pkg::OUT_MIN, opbf_pkg::chan_t'(5));
		send_sample(opbf_pkg::OUT_MAX, opbf_pkg::chan_t'(6));
		send_sample(opbf_pkg::OUT_MIN, opbf_pkg::chan_t'(5));
		send_sample(opbf_pkg::OUT_MAX, opbf_pkg::chan_t'(6));
		wait_for_results();
	endtask

	task automatic run_random_phase(input int count, input opbf_pkg::alpha_t lp,
			input opbf_pkg::alpha_t hp);
		opbf_pkg::chan_t c;
		set_coefficients(lp, hp);
		foreach (tone_base[i]) begin
			tone_base[i] = opbf_pkg::sample_t'($urandom);
		end
		repeat (count) begin
			c = opbf_pkg::chan_t'($urandom_range(NUM_CHANNELS - 1));
			send_sample(pick_sample(c), c);
		end
		wait_for_results();
	endtask

	// random content over a series of coefficient settings
	task automatic test_random_settings();
		run_random_phase(190, '1, '0);
		run_random_phase(190, '0, '1);
		repeat (6) run_random_phase(190, pick_alpha(), pick_alpha());
	endtask

	// a long stretch with neither side idling
	task automatic test_back_to_back();
		no_gaps = 1'b1;
		run_random_phase(180, pick_alpha(), pick_alpha());
		no_gaps = 1'b0;
	endtask

	// result side: random back-pressure
	always @(posedge clk) begin
		result_if.ready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			if (expected_samples.size() == 0) begin
				if (errors < MAX_REPORTS) begin
					$display("%0t: unexpected result %0d", $time, result_if.sample_out);
				end
				errors++;
			end else begin
				want = expected_samples.pop_front();
				if (result_if.sample_out !== want) begin
					if (errors < MAX_REPORTS) begin
						$display("%0t: sample_out expected %0d actual %0d",
							$time, want, result_if.sample_out);
					end
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (sample_if.valid && sample_if.ready) ||
				(result_if.valid && result_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("one_pole_bandpass_filter: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		foreach (lowpass_level[i]) begin
			lowpass_level[i]  = 0;
			highpass_level[i] = 0;
		end
		errors              = 0;
		quiet_cycles        = 0;
		no_gaps             = 1'b0;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = opbf_pkg::REG_LP_ALPHA;
		cfg_data            = '0;
		sample_if.valid     = 1'b0;
		sample_if.sample_in = '0;
		sample_if.channel   = '0;
		result_if.ready     = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_coefficient_extremes();
		test_saturation();
		test_random_settings();
		test_back_to_back();

		// let any stray result show up before the verdict
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_samples.size() != 0) begin
			errors++;
		end
		if (errors == 0) begin
			$display("one_pole_bandpass_filter: match");
		end else begin
			$display("one_pole_bandpass_filter: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire
